>>> rtl/blse_pkg.sv
// shared types, constants and float helpers for the lead byte size estimator
package blse_pkg;

   localparam int IDX_W = 10;
   localparam int LEN_W = 11;

   localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
   localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
   localparam logic [30:0] EB_RESET     = 31'd981668463;
   localparam logic [0:0]  REG_IDX_EB   = 1'b0;
   localparam logic signed [12:0] SGL_BIAS = 13'sd127;
   localparam logic signed [12:0] DBL_BIAS = 13'sd1023;
   localparam logic signed [12:0] DBL_INF_EXP = 13'sd1024;
   localparam logic signed [12:0] SUBN_BASE = 13'sd149;
   localparam logic signed [12:0] LEN_BASE = 13'sd10;
   localparam logic signed [12:0] LEN_MIN = 13'sd9;
   localparam logic signed [12:0] LEN_MAX = 13'sd32;

   typedef struct packed {
      logic [31:0]      min_val;
      logic [31:0]      max_val;
      logic [LEN_W-1:0] len;
      logic             bank;
   } blk_desc_type;

   typedef struct packed {
      logic             en;
      logic             bank;
      logic [IDX_W-1:0] idx;
      logic [31:0]      data;
   } mem_wr_type;

   function automatic logic f_is_nan(input logic [31:0] a);
      f_is_nan = (a[30:23] == EXP_ALL_ONES) && (a[22:0] != 23'd0);
   endfunction

   // ordered less-than, false when either side is nan
   function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
      logic res;
      res = 1'b0;
      if (f_is_nan(a) || f_is_nan(b)) begin
         res = 1'b0;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         res = 1'b0;
      end else if (a[31] && !b[31]) begin
         res = 1'b1;
      end else if (!a[31] && !b[31]) begin
         res = a[30:0] < b[30:0];
      end else if (a[31] && b[31]) begin
         res = a[30:0] > b[30:0];
      end
      f_lt = res;
   endfunction

   function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
      f_le = !f_is_nan(a) && !f_is_nan(b) &&
             (f_lt(a, b) || (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)));
   endfunction

   // divide by two with round to nearest even into the subnormal range
   function automatic logic [31:0] f_halve(input logic [31:0] a);
      logic [31:0] res;
      logic [23:0] m;
      logic [30:0] packed_mag;
      m = {a[23], a[22:0]};
      packed_mag = {8'd0, m[23:1]} + {30'd0, m[0] & m[1]};
      if (a[30:23] == EXP_ALL_ONES) begin
         res = f_is_nan(a) ? (a | QUIET_BIT) : a;
      end else if (a[30:24] != 7'd0) begin
         res = {a[31], a[30:23] - 8'd1, a[22:0]};
      end else begin
         res = {a[31], packed_mag};
      end
      f_halve = res;
   endfunction

endpackage

>>> rtl/block_lead_byte_size_estimator.sv
// top level of the block lead byte size estimator
// throughput: the intake takes one sample per cycle while one of two sample banks is free
// a block of n samples occupies the processing side for its passes through the shared
// three stage float adder: range, center, then one residual per stored sample
// reset: synchronous, clears control, min/max and fill state; error bound back to default
module block_lead_byte_size_estimator import blse_pkg::*; #(
   parameter int BLOCK_SIZE = 128
) (
   input  logic        clock,
   input  logic        reset,
   // sample items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample,
   input  logic        req_last_in_block,
   // block results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_constant,
   output logic [2:0]  rsp_required_bytes,
   output logic [8:0]  rsp_lead_byte_sum,
   output logic [31:0] rsp_half_range,
   output logic [31:0] rsp_block_center,
   output logic [7:0]  rsp_block_length,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // error bound register, only register of the block
   logic [30:0] eb_ff, eb_in;
   logic        csr_wr;

   always_comb begin
      csr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_IDX_EB);
      eb_in  = csr_wr ? csr_pwdata[30:0] : eb_ff;
      csr_prdata = (csr_paddr[2] == REG_IDX_EB) ? {1'b0, eb_ff} : 32'd0;
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eb_ff <= EB_RESET;
      end else begin
         eb_ff <= eb_in;
      end
   end

   // intake side: writes samples into the current bank, closes a block on last or full
   mem_wr_type   mem_wr;
   logic         blk_push;
   blk_desc_type blk_desc;
   logic         bank_release;

   blse_front #(.BLOCK_SIZE(BLOCK_SIZE)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_last_in_block (req_last_in_block),
      .bank_release      (bank_release),
      .mem_wr            (mem_wr),
      .blk_push          (blk_push),
      .blk_desc          (blk_desc)
   );

   // closed blocks wait here for the processing side
   logic         q_valid, q_pop, q_full;
   blk_desc_type q_desc;

   blse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (blk_push),
      .push_desc  (blk_desc),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_desc  (q_desc),
      .full       (q_full)
   );

   // processing side: owns the sample banks and the float adder
   blse_back #(.BLOCK_SIZE(BLOCK_SIZE)) u_back (
      .clock              (clock),
      .reset              (reset),
      .mem_wr             (mem_wr),
      .q_valid            (q_valid),
      .q_desc             (q_desc),
      .q_pop              (q_pop),
      .error_bound        (eb_ff),
      .bank_release       (bank_release),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_constant    (rsp_is_constant),
      .rsp_required_bytes (rsp_required_bytes),
      .rsp_lead_byte_sum  (rsp_lead_byte_sum),
      .rsp_half_range     (rsp_half_range),
      .rsp_block_center   (rsp_block_center),
      .rsp_block_length   (rsp_block_length)
   );

   // a closed block always finds room in the queue
   assert property (@(posedge clock) disable iff (reset) !(blk_push && q_full))
      else $error("block queue overflow");

   // a constant block reports neither bytes nor leading bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_constant |-> (rsp_required_bytes == 3'd0) &&
                                      (rsp_lead_byte_sum == 9'd0))
      else $error("constant block with nonzero size fields");

   // a nonconstant block needs two to four bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_constant |-> (rsp_required_bytes >= 3'd2) &&
                                       (rsp_required_bytes <= 3'd4))
      else $error("required bytes out of range");

   // a bank is released only together with loading a result into the output register
   assert property (@(posedge clock) disable iff (reset) bank_release |=> rsp_valid)
      else $error("bank released without a result");

endmodule

>>> rtl/blse_fadd.sv
// three stage single precision adder and subtracter, round to nearest even
module blse_fadd import blse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_a,
   input  logic [31:0] in_b,
   input  logic        in_sub,
   output logic        out_valid,
   output logic [31:0] out_sum
);

   // stage 1: specials, swap, align
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_sign_ff, s1_sign_in;
   logic [7:0]  s1_exp_ff, s1_exp_in;
   logic [26:0] s1_ma_ff, s1_ma_in;
   logic [26:0] s1_mb_ff, s1_mb_in;
   logic        s1_esub_ff, s1_esub_in;
   logic        s1_spec_ff, s1_spec_in;
   logic [31:0] s1_sval_ff, s1_sval_in;

   logic        b_sign, a_nan, b_nan, a_inf, b_inf, swap;
   logic [31:0] big, lesser;
   logic        big_s, small_s;
   logic [7:0]  big_e, small_e, dexp;
   logic [26:0] mb_raw, mb_mask;

   always_comb begin
      b_sign  = in_b[31] ^ in_sub;
      a_nan   = f_is_nan(in_a);
      b_nan   = f_is_nan(in_b);
      a_inf   = (in_a[30:23] == EXP_ALL_ONES) && (in_a[22:0] == 23'd0);
      b_inf   = (in_b[30:23] == EXP_ALL_ONES) && (in_b[22:0] == 23'd0);
      swap    = in_b[30:0] > in_a[30:0];
      big     = swap ? in_b : in_a;
      lesser  = swap ? in_a : in_b;
      big_s   = swap ? b_sign : in_a[31];
      small_s = swap ? in_a[31] : b_sign;
      big_e   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      small_e = (lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23];
      dexp    = big_e - small_e;
      mb_raw  = {lesser[30:23] != 8'd0, lesser[22:0], 3'b000};
      s1_ma_in = {big[30:23] != 8'd0, big[22:0], 3'b000};
      if (dexp >= 8'd27) begin
         s1_mb_in = {26'd0, |mb_raw};
      end else begin
         mb_mask  = ~(27'h7FF_FFFF << dexp[4:0]);
         s1_mb_in = (mb_raw >> dexp[4:0]) | {26'd0, |(mb_raw & mb_mask)};
      end
      if (dexp < 8'd27) begin
         mb_mask = ~(27'h7FF_FFFF << dexp[4:0]);
      end else begin
         mb_mask = 27'h7FF_FFFF;
      end
      s1_valid_in = in_valid;
      s1_sign_in  = big_s;
      s1_exp_in   = big_e;
      s1_esub_in  = big_s != small_s;
      s1_spec_in  = 1'b1;
      priority if (a_nan) begin
         s1_sval_in = in_a | QUIET_BIT;
      end else if (b_nan) begin
         s1_sval_in = in_b | QUIET_BIT;
      end else if (a_inf && b_inf && (in_a[31] != b_sign)) begin
         s1_sval_in = QNAN_DEFAULT;
      end else if (a_inf) begin
         s1_sval_in = in_a;
      end else if (b_inf) begin
         s1_sval_in = {b_sign, in_b[30:0]};
      end else begin
         s1_spec_in = 1'b0;
         s1_sval_in = 32'd0;
      end
   end

   // stage 2: magnitude add or subtract
   logic        s2_valid_ff;
   logic        s2_sign_ff;
   logic [7:0]  s2_exp_ff;
   logic [27:0] s2_sum_ff, s2_sum_in;
   logic        s2_esub_ff;
   logic        s2_spec_ff;
   logic [31:0] s2_sval_ff;

   always_comb begin
      if (s1_esub_ff) begin
         s2_sum_in = {1'b0, s1_ma_ff} - {1'b0, s1_mb_ff};
      end else begin
         s2_sum_in = {1'b0, s1_ma_ff} + {1'b0, s1_mb_ff};
      end
   end

   // stage 3: normalize and round
   logic        out_valid_ff;
   logic [31:0] out_sum_ff, out_sum_in;
   logic [4:0]  lz;
   logic [7:0]  sh;
   logic [26:0] mant;
   logic [8:0]  exp9;
   logic [7:0]  efield;
   logic        rnd;
   logic [30:0] mag;

   always_comb begin
      lz = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (s2_sum_ff[i]) begin
            lz = 5'(26 - i);
         end
      end
      sh = ({3'd0, lz} < (s2_exp_ff - 8'd1)) ? {3'd0, lz} : (s2_exp_ff - 8'd1);
      if (s2_sum_ff[27]) begin
         mant = {s2_sum_ff[27:2], s2_sum_ff[1] | s2_sum_ff[0]};
         exp9 = {1'b0, s2_exp_ff} + 9'd1;
      end else begin
         mant = s2_sum_ff[26:0] << sh;
         exp9 = {1'b0, s2_exp_ff} - {1'b0, sh};
      end
      efield = mant[26] ? exp9[7:0] : 8'd0;
      rnd    = mant[2] & (mant[1] | mant[0] | mant[3]);
      mag    = {efield, mant[25:3]} + {30'd0, rnd};
      if (s2_spec_ff) begin
         out_sum_in = s2_sval_ff;
      end else if (s2_sum_ff == 28'd0) begin
         out_sum_in = {s2_esub_ff ? 1'b0 : s2_sign_ff, 31'd0};
      end else if (exp9 >= 9'd255) begin
         out_sum_in = {s2_sign_ff, EXP_ALL_ONES, 23'd0};
      end else begin
         out_sum_in = {s2_sign_ff, mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
      s1_sign_ff <= s1_sign_in;
      s1_exp_ff  <= s1_exp_in;
      s1_ma_ff   <= s1_ma_in;
      s1_mb_ff   <= s1_mb_in;
      s1_esub_ff <= s1_esub_in;
      s1_spec_ff <= s1_spec_in;
      s1_sval_ff <= s1_sval_in;
      s2_sign_ff <= s1_sign_ff;
      s2_exp_ff  <= s1_exp_ff;
      s2_sum_ff  <= s2_sum_in;
      s2_esub_ff <= s1_esub_ff;
      s2_spec_ff <= s1_spec_ff;
      s2_sval_ff <= s1_sval_ff;
      out_sum_ff <= out_sum_in;
   end

   assign out_valid = out_valid_ff;
   assign out_sum   = out_sum_ff;

endmodule

>>> rtl/blse_queue.sv
// two entry queue of finished block descriptors
module blse_queue import blse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  blk_desc_type push_desc,
   input  logic         pop,
   output logic         head_valid,
   output blk_desc_type head_desc,
   output logic         full
);

   blk_desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      do_push   = push && (cnt_ff != 2'd2);
      do_pop    = pop && (cnt_ff != 2'd0);
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_valid = cnt_ff != 2'd0;
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign full       = cnt_ff == 2'd2;

endmodule

>>> rtl/blse_front.sv
// intake: stores samples into a bank, tracks min and max, closes blocks
module blse_front import blse_pkg::*; #(
   parameter int BLOCK_SIZE = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [31:0]  req_sample,
   input  logic         req_last_in_block,
   input  logic         bank_release,
   output mem_wr_type   mem_wr,
   output logic         blk_push,
   output blk_desc_type blk_desc
);

   localparam int AW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

   logic [AW-1:0] fill_ff, fill_in;
   logic          bank_ff, bank_in;
   logic [1:0]    busy_ff, busy_in;
   logic [31:0]   min_ff, min_in;
   logic [31:0]   max_ff, max_in;
   logic          accept, blk_end;

   always_comb begin
      req_ready = busy_ff != 2'd2;
      accept    = req_valid && req_ready;
      blk_end   = req_last_in_block || (fill_ff == AW'(BLOCK_SIZE - 1));
      min_in    = min_ff;
      max_in    = max_ff;
      fill_in   = fill_ff;
      bank_in   = bank_ff;
      if (accept) begin
         if (fill_ff == '0) begin
            min_in = req_sample;
            max_in = req_sample;
         end else if (f_lt(req_sample, min_ff)) begin
            min_in = req_sample;
         end else if (f_lt(max_ff, req_sample)) begin
            max_in = req_sample;
         end
         if (blk_end) begin
            fill_in = '0;
            bank_in = ~bank_ff;
         end else begin
            fill_in = fill_ff + AW'(1);
         end
      end
      blk_push         = accept && blk_end;
      blk_desc.min_val = min_in;
      blk_desc.max_val = max_in;
      blk_desc.len     = LEN_W'(fill_ff) + LEN_W'(1);
      blk_desc.bank    = bank_ff;
      busy_in          = busy_ff + {1'b0, blk_push} - {1'b0, bank_release};
      mem_wr.en        = accept;
      mem_wr.bank      = bank_ff;
      mem_wr.idx       = IDX_W'(fill_ff);
      mem_wr.data      = req_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'd0;
         min_ff  <= 32'd0;
         max_ff  <= 32'd0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
      end
   end

endmodule

>>> rtl/blse_back.sv
// block processing: range, center, length plan and residual walk over the stored bank
module blse_back import blse_pkg::*; #(
   parameter int BLOCK_SIZE = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  mem_wr_type   mem_wr,
   input  logic         q_valid,
   input  blk_desc_type q_desc,
   output logic         q_pop,
   input  logic [30:0]  error_bound,
   output logic         bank_release,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_is_constant,
   output logic [2:0]   rsp_required_bytes,
   output logic [8:0]   rsp_lead_byte_sum,
   output logic [31:0]  rsp_half_range,
   output logic [31:0]  rsp_block_center,
   output logic [7:0]   rsp_block_length
);

   localparam int AW    = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int DEPTH = 2 ** (AW + 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RANGE  = 7'b0000010,
      ST_MID_GO = 7'b0000100,
      ST_MID    = 7'b0001000,
      ST_PLAN   = 7'b0010000,
      ST_WALK   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } bk_state_type;

   logic [31:0] store [DEPTH];

   bk_state_type st_ff, st_in;
   blk_desc_type desc_ff, desc_in;
   logic [31:0]  radius_ff, radius_in;
   logic [31:0]  center_ff, center_in;
   logic [31:0]  wcenter_ff, wcenter_in;
   logic         const_ff, const_in;
   logic [2:0]   bytes_ff, bytes_in;
   logic [2:0]   shift_ff, shift_in;
   logic [LEN_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0] done_ff, done_in;
   logic         rd_vld_ff, rd_en;
   logic [31:0]  rd_data_ff;
   logic [AW:0]  rd_addr;
   logic [31:0]  prev_ff, prev_in;
   logic [8:0]   sum_ff, sum_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_const_ff;
   logic [2:0]   rsp_bytes_ff;
   logic [8:0]   rsp_sum_ff;
   logic [31:0]  rsp_half_ff, rsp_center_ff;
   logic [7:0]   rsp_len_ff;
   logic         rsp_load;

   logic         add_valid, add_sub, add_out_valid;
   logic [31:0]  add_a, add_b, add_out;

   logic signed [12:0] rexp, bexp, req13;
   logic [5:0]   req6;
   logic         zero_center;
   logic [4:0]   eb_msb;
   logic [31:0]  cur, xr;
   logic [1:0]   lead, capped;

   blse_fadd u_fadd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (add_valid),
      .in_a      (add_a),
      .in_b      (add_b),
      .in_sub    (add_sub),
      .out_valid (add_out_valid),
      .out_sum   (add_out)
   );

   // exponents for the length estimate
   always_comb begin
      eb_msb = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (error_bound[i]) begin
            eb_msb = 5'(i);
         end
      end
      rexp = $signed({5'd0, radius_ff[30:23]}) - SGL_BIAS;
      if (error_bound[30:23] == EXP_ALL_ONES) begin
         bexp = DBL_INF_EXP;
      end else if (error_bound[30:23] != 8'd0) begin
         bexp = $signed({5'd0, error_bound[30:23]}) - SGL_BIAS;
      end else if (error_bound[22:0] == 23'd0) begin
         bexp = -DBL_BIAS;
      end else begin
         bexp = $signed({8'd0, eb_msb}) - SUBN_BASE;
      end
      req13       = LEN_BASE + rexp - bexp;
      zero_center = 1'b0;
      if (req13 < LEN_MIN) begin
         req6 = 6'(LEN_MIN);
      end else if (req13 > LEN_MAX) begin
         req6        = 6'(LEN_MAX);
         zero_center = 1'b1;
      end else begin
         req6 = req13[5:0];
      end
   end

   // residual of one walked sample
   always_comb begin
      cur = 32'($signed(add_out) >>> shift_ff);
      xr  = cur ^ prev_ff;
      priority if (xr[31:8] == 24'd0) begin
         lead = 2'd3;
      end else if (xr[31:16] == 16'd0) begin
         lead = 2'd2;
      end else if (xr[31:24] == 8'd0) begin
         lead = 2'd1;
      end else begin
         lead = 2'd0;
      end
      capped = ({1'b0, lead} >= bytes_ff) ? bytes_ff[1:0] : lead;
   end

   always_comb begin
      st_in        = st_ff;
      desc_in      = desc_ff;
      radius_in    = radius_ff;
      center_in    = center_ff;
      wcenter_in   = wcenter_ff;
      const_in     = const_ff;
      bytes_in     = bytes_ff;
      shift_in     = shift_ff;
      rd_idx_in    = rd_idx_ff;
      done_in      = done_ff;
      prev_in      = prev_ff;
      sum_in       = sum_ff;
      rd_en        = 1'b0;
      rd_addr      = {desc_ff.bank, rd_idx_ff[AW-1:0]};
      q_pop        = 1'b0;
      bank_release = 1'b0;
      rsp_load     = 1'b0;
      add_valid    = 1'b0;
      add_a        = desc_ff.min_val;
      add_b        = radius_ff;
      add_sub      = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            add_a = q_desc.max_val;
            add_b = q_desc.min_val;
            add_sub = 1'b1;
            if (q_valid) begin
               q_pop     = 1'b1;
               add_valid = 1'b1;
               desc_in   = q_desc;
               st_in     = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (add_out_valid) begin
               radius_in = f_halve(add_out);
               st_in     = ST_MID_GO;
            end
         end
         ST_MID_GO: begin
            add_valid = 1'b1;
            st_in     = ST_MID;
         end
         ST_MID: begin
            if (add_out_valid) begin
               center_in = add_out;
               st_in     = ST_PLAN;
            end
         end
         ST_PLAN: begin
            const_in   = f_le(radius_ff, {1'b0, error_bound});
            bytes_in   = req6[5:3] + {2'd0, req6[2:0] != 3'd0};
            shift_in   = (req6[2:0] == 3'd0) ? 3'd0 : 3'(4'd8 - {1'b0, req6[2:0]});
            wcenter_in = zero_center ? 32'd0 : center_ff;
            rd_idx_in  = '0;
            done_in    = '0;
            prev_in    = 32'd0;
            sum_in     = 9'd0;
            st_in      = f_le(radius_ff, {1'b0, error_bound}) ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            add_valid = rd_vld_ff;
            add_a     = rd_data_ff;
            add_b     = wcenter_ff;
            add_sub   = 1'b1;
            if (rd_idx_ff < desc_ff.len) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + LEN_W'(1);
            end
            if (add_out_valid) begin
               prev_in = cur;
               sum_in  = sum_ff + 9'(capped);
               done_in = done_ff + LEN_W'(1);
               if (done_ff + LEN_W'(1) == desc_ff.len) begin
                  st_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               bank_release = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         store[{mem_wr.bank, mem_wr.idx[AW-1:0]}] <= mem_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
      desc_ff    <= desc_in;
      radius_ff  <= radius_in;
      center_ff  <= center_in;
      wcenter_ff <= wcenter_in;
      const_ff   <= const_in;
      bytes_ff   <= bytes_in;
      shift_ff   <= shift_in;
      rd_idx_ff  <= rd_idx_in;
      done_ff    <= done_in;
      prev_ff    <= prev_in;
      sum_ff     <= sum_in;
      if (rsp_load) begin
         rsp_const_ff  <= const_ff;
         rsp_bytes_ff  <= const_ff ? 3'd0 : bytes_ff;
         rsp_sum_ff    <= const_ff ? 9'd0 : sum_ff;
         rsp_half_ff   <= radius_ff;
         rsp_center_ff <= center_ff;
         rsp_len_ff    <= desc_ff.len[7:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_constant    = rsp_const_ff;
   assign rsp_required_bytes = rsp_bytes_ff;
   assign rsp_lead_byte_sum  = rsp_sum_ff;
   assign rsp_half_range     = rsp_half_ff;
   assign rsp_block_center   = rsp_center_ff;
   assign rsp_block_length   = rsp_len_ff;

endmodule
